>>> rtl/cartridge_bank_controller_top_assert.svh
// Assertion macros used by the RTL of the cartridge bank controller.
`ifndef CARTRIDGE_BANK_CONTROLLER_TOP_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cbc_pkg.sv
`default_nettype none

package cbc_pkg;

  typedef enum logic [2:0] {
    KIND_ROM  = 3'd0,
    KIND_MBC1 = 3'd1,
    KIND_MBC2 = 3'd2,
    KIND_MBC3 = 3'd3,
    KIND_MBC5 = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_RAM  = 2'd2,
    TGT_OPEN = 2'd3
  } target_t;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_READ  = 1'b1
  } action_t;

  localparam int unsigned PaddrW = 4;

  localparam logic [1:0] REG_KIND     = 2'd0;
  localparam logic [1:0] REG_ROM_SIZE = 2'd1;
  localparam logic [1:0] REG_RAM_SIZE = 2'd2;

  localparam logic [23:0] RomSizeReset = 24'd32768;

  typedef struct packed {
    logic        action;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [22:0] physical_address;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/cartridge_bank_controller_top.sv
`default_nettype none

// Cartridge bank controller for ROM-only, MBC1, MBC2, MBC3 and MBC5 carts. Every bus
// access is one request on the in_ channel and yields exactly one result on the out_
// channel. While results are drained a request is taken every cycle; a request waits
// in the input register; its decoded result is driven on out_ by the result register.
// When out_ready is low with a result pending the result register holds, and in_ready
// drops once the input register is also occupied. Requests are resolved strictly in
// order in the decode stage, so a bank write is seen by the very next access. The user
// writes the configuration registers (kind at 0x0, ROM size at 0x4, RAM size at 0x8)
// through the APB port only while the block is idle; the block does not enforce this.
module cartridge_bank_controller_top (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire cbc_pkg::in_item_t        in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output cbc_pkg::out_item_t            out_data,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [cbc_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import cbc_pkg::*;

  logic [2:0]  kind_r;
  logic [23:0] rom_size_r;
  logic [16:0] ram_size_r;

  logic [8:0]  rom_bank_r, rom_bank_nxt;
  logic [7:0]  ram_bank_r, ram_bank_nxt;
  logic        mode_r, mode_nxt;
  logic        ram_enable_r, ram_enable_nxt;

  logic        s1_valid_r;
  in_item_t    s1_r;
  logic        out_valid_r;
  out_item_t   out_item_r, out_item_nxt;
  logic        advance;
  logic        cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r     <= KIND_ROM;
      rom_size_r <= RomSizeReset;
      ram_size_r <= '0;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        REG_KIND:     kind_r     <= pwdata[2:0];
        REG_ROM_SIZE: rom_size_r <= pwdata[23:0];
        REG_RAM_SIZE: ram_size_r <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_KIND:     prdata = {29'd0, kind_r};
      REG_ROM_SIZE: prdata = {8'd0, rom_size_r};
      REG_RAM_SIZE: prdata = {15'd0, ram_size_r};
      default:      prdata = '0;
    endcase
  end

  // The decode stage moves whenever the result register is free or being drained.
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r <= in_data;
    end
  end

  // Decode of the request held in the input register.
  logic [15:0] a;
  logic [7:0]  v;
  logic [8:0]  eff_bank;
  logic [22:0] rom_idx;
  logic [15:0] ram_off;
  logic        is_mbc;

  always_comb begin
    a = s1_r.bus_address;
    v = s1_r.write_data;
    rom_bank_nxt   = rom_bank_r;
    ram_bank_nxt   = ram_bank_r;
    mode_nxt       = mode_r;
    ram_enable_nxt = ram_enable_r;
    out_item_nxt   = '{target: TGT_NONE, physical_address: '0};

    is_mbc = (kind_r == KIND_MBC1) || (kind_r == KIND_MBC2) ||
             (kind_r == KIND_MBC3) || (kind_r == KIND_MBC5);

    // A zero bank selects bank 1 on every kind except MBC5.
    eff_bank = rom_bank_r;
    if (rom_bank_r == 9'd0 && kind_r != KIND_MBC5) begin
      eff_bank = 9'd1;
    end
    rom_idx = {eff_bank, a[13:0]};
    // The RAM offset wraps at 16 bits, so only the low three bank bits survive.
    ram_off = {ram_bank_r[2:0], a[12:0]};

    if (s1_r.action == ACT_WRITE) begin
      if (is_mbc) begin
        if (a[15:13] == 3'b000) begin
          ram_enable_nxt = (v[3:0] == 4'hA);
        end else begin
          case (kind_r)
            KIND_MBC1: begin
              if (a[15:13] == 3'b001) begin
                rom_bank_nxt = {rom_bank_r[8:7], rom_bank_r[6:5],
                                (v[4:0] == 5'd0) ? 5'd1 : v[4:0]};
                rom_bank_nxt[8:7] = 2'b00;
              end else if (a[15:13] == 3'b010) begin
                if (!mode_r) begin
                  rom_bank_nxt = {2'b00, v[1:0], rom_bank_r[4:0]};
                end else begin
                  ram_bank_nxt = {6'd0, v[1:0]};
                end
              end else if (a[15:13] == 3'b011) begin
                mode_nxt = v[0];
              end
            end
            KIND_MBC2: begin
              if (a[15:13] == 3'b001) begin
                rom_bank_nxt = {5'd0, (v[3:0] == 4'd0) ? 4'd1 : v[3:0]};
              end
            end
            KIND_MBC3: begin
              if (a[15:13] == 3'b001) begin
                rom_bank_nxt = {2'd0, (v[6:0] == 7'd0) ? 7'd1 : v[6:0]};
              end else if (a[15:13] == 3'b010) begin
                ram_bank_nxt = v;
              end
            end
            KIND_MBC5: begin
              if (a[15:12] == 4'h2) begin
                rom_bank_nxt = {rom_bank_r[8], v};
              end else if (a[15:12] == 4'h3) begin
                rom_bank_nxt = {v[0], rom_bank_r[7:0]};
              end
            end
            default: ;
          endcase
        end
      end
    end else if (a[15:14] == 2'b01) begin
      if ({1'b0, rom_idx} < rom_size_r) begin
        out_item_nxt = '{target: TGT_ROM, physical_address: rom_idx};
      end else begin
        out_item_nxt.target = TGT_OPEN;
      end
    end else if (a[15:13] == 3'b101) begin
      if (ram_enable_r && ram_size_r != 17'd0 && {1'b0, ram_off} < ram_size_r) begin
        out_item_nxt = '{target: TGT_RAM, physical_address: {7'd0, ram_off}};
      end else begin
        out_item_nxt.target = TGT_OPEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r   <= 9'd1;
      ram_bank_r   <= '0;
      mode_r       <= 1'b0;
      ram_enable_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        rom_bank_r   <= rom_bank_nxt;
        ram_bank_r   <= ram_bank_nxt;
        mode_r       <= mode_nxt;
        ram_enable_r <= ram_enable_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

`include "cartridge_bank_controller_top_assert.svh"

  `CBC_ASSERT_NEXT(a_write_gives_none, advance && s1_valid_r && s1_r.action == ACT_WRITE,
    out_item_r.target == TGT_NONE && out_item_r.physical_address == 23'd0,
    "write request produced a non-empty result")
  `CBC_ASSERT_NOW(a_ram_hit_enabled, out_valid_r && out_item_r.target == TGT_RAM,
    ram_enable_r && out_item_r.physical_address < {6'd0, ram_size_r},
    "RAM result while RAM is disabled or beyond its size")
  `CBC_ASSERT_NOW(a_rom_hit_in_range, out_valid_r && out_item_r.target == TGT_ROM,
    {1'b0, out_item_r.physical_address} < rom_size_r,
    "ROM result beyond the configured ROM size")
  `CBC_ASSERT_NEXT(a_stall_holds_state, out_valid_r && !out_ready,
    $stable(rom_bank_r) && $stable(ram_bank_r) && $stable(ram_enable_r),
    "bank state changed while the result was stalled")

endmodule

`default_nettype wire
